### src/hsl_to_rgb_bytes_defines.svh
// assertion macros for the hsl to rgb converter
// used by the top level only; needs a clk and rst_n in the including scope
`ifndef HSL_TO_RGB_BYTES_DEFINES_SVH
`define HSL_TO_RGB_BYTES_DEFINES_SVH

`ifndef SYNTH

// condition holds at every clock edge out of reset
`define HSL2RGB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: cond");

// when pre holds, post holds at the next clock edge
`define HSL2RGB_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: pre then post");

`else

`define HSL2RGB_ASSERT_ALWAYS(label, cond)

`define HSL2RGB_ASSERT_NEXT(label, pre, post)

`endif

`endif

### src/hsl2rgb_pkg.sv
// shared types, constants and the hue term function for the hsl to rgb converter
// no dependencies
`default_nettype none

package hsl2rgb_pkg;

    // hue in 1/16 degree, one full turn
    localparam int HUE_FULL = 5760;
    // one unit of the channel phase k
    localparam int K_UNIT   = 480;
    localparam int K_LO     = 3 * K_UNIT;
    localparam int K_HI     = 9 * K_UNIT;

    // phase offsets for red, green and blue (n = 0, 8, 4)
    localparam logic [12:0] CHAN_OFFSET [0:2] = '{13'd0, 13'd3840, 13'd1920};

    // y = 61200 + 128*122400 - s*m*t, always positive
    localparam logic signed [26:0] Y_BIAS = 27'sd15728400;
    // 122400 = 32 * 3825; divide by 32 is a shift, then by 3825
    localparam logic [11:0]  DIV_C = 12'd3825;
    // floor(2^32 / 3825)
    localparam logic [20:0]  RECIP = 21'd1122867;
    localparam logic signed [9:0] Q_BIAS = 10'sd128;

    typedef struct packed {
        logic [12:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  lightness;
    } hsl_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // load strobes for the channel pipeline stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // clamp(min(k-3, 9-k), -1, 1) in units of 1/480
    function automatic logic signed [10:0] chan_term(input logic [12:0] hue_w,
                                                     input logic [12:0] off);
        logic [13:0]        sum;
        logic [13:0]        sum_wrap;
        logic [12:0]        k;
        logic signed [13:0] t1;
        logic signed [13:0] t2;
        logic signed [13:0] t;
        sum      = {1'b0, hue_w} + {1'b0, off};
        sum_wrap = sum - 14'(HUE_FULL);
        k        = (sum >= 14'(HUE_FULL)) ? sum_wrap[12:0] : sum[12:0];
        t1       = $signed({1'b0, k}) - $signed(14'(K_LO));
        t2       = $signed(14'(K_HI)) - $signed({1'b0, k});
        t        = (t1 < t2) ? t1 : t2;
        if (t > $signed(14'(K_UNIT)))
            t = $signed(14'(K_UNIT));
        if (t < -$signed(14'(K_UNIT)))
            t = -$signed(14'(K_UNIT));
        return t[10:0];
    endfunction

endpackage

`default_nettype wire

### src/hsl2rgb_chan.sv
// one color channel: product with the hue term, divide by 122400, round, clamp
// depends on hsl2rgb_pkg
`default_nettype none

module hsl2rgb_chan import hsl2rgb_pkg::*;
(
    input  wire logic               clk,
    input  wire stage_en_t          en,
    input  wire logic [14:0]        sm,
    input  wire logic signed [10:0] term,
    input  wire logic [7:0]         lightness,
    output logic [7:0]              value
);

    logic signed [15:0] sm_s;
    logic signed [26:0] prod_p;
    logic signed [26:0] y;
    logic [19:0]        yd_next;
    logic [19:0]        yd_reg;
    logic [7:0]         l2_reg;
    logic [40:0]        recip_prod;
    logic [7:0]         qe_next;
    logic [7:0]         qe_reg;
    logic [19:0]        yd3_reg;
    logic [7:0]         l3_reg;
    logic [19:0]        qd;
    logic [19:0]        rem;
    logic [8:0]         q_fix;
    logic signed [9:0]  q_sum;
    logic [7:0]         value_next;
    logic [7:0]         value_reg;

    // stage 2: biased numerator, already divided by 32
    always_comb
    begin
        sm_s    = $signed({1'b0, sm});
        prod_p  = sm_s * term;
        y       = Y_BIAS - prod_p;
        yd_next = y[24:5];
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            yd_reg <= yd_next;
            l2_reg <= lightness;
        end
    end

    // stage 3: quotient estimate by reciprocal, low by at most one
    always_comb
    begin
        recip_prod = 41'(yd_reg) * 41'(RECIP);
        qe_next    = recip_prod[39:32];
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            qe_reg  <= qe_next;
            yd3_reg <= yd_reg;
            l3_reg  <= l2_reg;
        end
    end

    // stage 4: fix the estimate, add lightness, clamp to a byte
    always_comb
    begin
        qd    = 20'(qe_reg) * 20'(DIV_C);
        rem   = yd3_reg - qd;
        q_fix = {1'b0, qe_reg} + ((rem >= 20'(DIV_C)) ? 9'd1 : 9'd0);
        q_sum = $signed({2'b00, l3_reg}) + $signed({1'b0, q_fix}) - Q_BIAS;
        if (q_sum < 10'sd0)
            value_next = 8'd0;
        else if (q_sum > 10'sd255)
            value_next = 8'd255;
        else
            value_next = q_sum[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### src/hsl_to_rgb_bytes.sv
// hsl to rgb byte converter, pipeline control, hue stage and three channels
// depends on hsl2rgb_pkg, hsl2rgb_chan and hsl_to_rgb_bytes_defines.svh
//
// Usage:
// - input channel hsl (hsl_valid/hsl_ready) carries hue in 1/16 degree,
//   saturation and lightness as fractions of 255; hue wraps at 360 degrees
// - output channel rgb (rgb_valid/rgb_ready) carries red, green, blue bytes
// - one rgb item per hsl item, in order
// - rgb_valid rises once the accepted item has passed through four register
//   stages: hue term and s*m product, numerator, reciprocal quotient,
//   correction and clamp into the output register
// - throughput is one item per cycle while rgb_ready is high
// - a stall on rgb_ready holds every full stage; empty stages keep filling,
//   so hsl_ready drops only once all four stages hold an item
// - reset empties the pipeline; no result is shown until an item is taken
`default_nettype none
`include "hsl_to_rgb_bytes_defines.svh"

module hsl_to_rgb_bytes import hsl2rgb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic hsl_valid,
    output logic      hsl_ready,
    input  wire hsl_t hsl,
    output logic      rgb_valid,
    input  wire logic rgb_ready,
    output rgb_t      rgb
);

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               v4_reg;
    logic               ready1;
    logic               ready2;
    logic               ready3;
    logic               ready4;
    stage_en_t          en;
    logic [12:0]        hue_w;
    logic [12:0]        hue_sub;
    logic [6:0]         m;
    logic [14:0]        sm_next;
    logic [14:0]        sm_reg;
    logic [7:0]         l1_reg;
    logic signed [10:0] term_next [0:2];
    logic signed [10:0] term_reg  [0:2];
    logic [7:0]         chan_value [0:2];

    // stage ready chain, a stage moves when the next one has room
    always_comb
    begin
        ready4    = !v4_reg || rgb_ready;
        ready3    = !v3_reg || ready4;
        ready2    = !v2_reg || ready3;
        ready1    = !v1_reg || ready2;
        hsl_ready = ready1;
        en.s2     = ready2 && v1_reg;
        en.s3     = ready3 && v2_reg;
        en.s4     = ready4 && v3_reg;
    end

    // valid bits follow the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= hsl_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
            if (ready4)
                v4_reg <= v3_reg;
        end
    end

    // stage 1: wrap hue, per channel hue term, chroma product s*min(l, 255-l)
    always_comb
    begin
        hue_sub = hsl.hue - 13'(HUE_FULL);
        hue_w   = (hsl.hue >= 13'(HUE_FULL)) ? hue_sub : hsl.hue;
        m       = hsl.lightness[7] ? ~hsl.lightness[6:0] : hsl.lightness[6:0];
        sm_next = 15'(hsl.saturation) * 15'(m);
        for (int c = 0; c < 3; c++)
            term_next[c] = chan_term(hue_w, CHAN_OFFSET[c]);
    end

    always_ff @(posedge clk)
    begin
        if (hsl_valid && ready1)
        begin
            sm_reg <= sm_next;
            l1_reg <= hsl.lightness;
            for (int c = 0; c < 3; c++)
                term_reg[c] <= term_next[c];
        end
    end

    // stages 2 to 4 per channel
    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        hsl2rgb_chan u_chan
        (
            .clk       (clk),
            .en        (en),
            .sm        (sm_reg),
            .term      (term_reg[c]),
            .lightness (l1_reg),
            .value     (chan_value[c])
        );
    end

    assign rgb_valid = v4_reg;
    assign rgb.red   = chan_value[0];
    assign rgb.green = chan_value[1];
    assign rgb.blue  = chan_value[2];

    // an empty output stage never blocks the input
    `HSL2RGB_ASSERT_ALWAYS(a_ready_when_out_empty, !rgb_valid -> hsl_ready)

    // a stalled stage 1 keeps its item and data
    `HSL2RGB_ASSERT_NEXT(a_stage1_hold, v1_reg && !ready2, v1_reg && $stable(sm_reg) && $stable(l1_reg))

    // input blocked only when every stage is full
    `HSL2RGB_ASSERT_ALWAYS(a_block_only_full, !hsl_ready -> (v1_reg && v2_reg && v3_reg && v4_reg))

endmodule

`default_nettype wire
